// File: rtl/core/double_ended_queue_macros.svh
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Checked on every edge outside reset.
`define DQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/dq_pkg.sv
// Shared constants and types for the deque.
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // input tdata: command, push_value, padded to bytes
    localparam int S_TDATA_W = 40;

    // command codes
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // cell operations
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/dq_cell.sv
// One storage cell of the deque chain.
`default_nettype none

module dq_cell #(
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dq_pkg::cell_ctrl_t    ctrl,
    input  wire logic                  left_valid,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic                  right_valid,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic [DATA_WIDTH-1:0] right_tail,
    input  wire logic [DATA_WIDTH-1:0] push_word,
    output logic                       valid,
    output logic [DATA_WIDTH-1:0]      data,
    output logic [DATA_WIDTH-1:0]      tail
);
    import dq_pkg::*;

    logic                  valid_reg, valid_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [DATA_WIDTH-1:0] tail_reg, tail_next;
    logic                  is_last;

    assign is_last = valid_reg && !right_valid;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctrl.op)
            OP_PUSH_FRONT: begin
                valid_next = left_valid;
                data_next  = left_data;
            end
            OP_POP_FRONT: begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            OP_PUSH_BACK: begin
                if (!valid_reg && left_valid) begin
                    valid_next = 1'b1;
                    data_next  = push_word;
                end
            end
            OP_POP_BACK: begin
                if (is_last) valid_next = 1'b0;
            end
            default: ;
        endcase
        // back word ripples toward cell zero, one cell per cycle
        tail_next = is_last ? data_reg : right_tail;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        tail_reg <= tail_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign tail  = tail_reg;

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue.sv
// Top level: deque as a chain of cells with command control and output register.
// Push and pop-front results appear in the cycle after the input transfer; a pop
// from the back waits in ST_WAIT while the back word ripples down the cell chain.
// Throughput: 1 command per cycle unless the output stalls; pop-back holds the input.
// Refused commands (push when full, pop when empty) complete without a wait state.
// Reset (aresetn low, synchronous) clears the valid bits, count and control; no sweep.
`default_nettype none
`include "double_ended_queue_macros.svh"

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1),
    parameter int M_TDATA_W  = ((35 + CNT_W + 7) / 8) * 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: [1:0] command, [33:2] push_value, [39:34] zero
    input  wire logic [dq_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // m_tdata: [31:0] popped_value, [33:32] status, [34+CNT_W-1:34] entry_count,
    //          [34+CNT_W] is_empty, rest zero
    output logic [M_TDATA_W-1:0]              m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready
);
    import dq_pkg::*;

    localparam int WAIT_W = $clog2(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WAIT = 1'b1;

    // unpacked input fields
    logic [1:0]            cmd;
    logic [31:0]           push_value;
    logic [63:0]           push_wide;
    logic [DATA_WIDTH-1:0] push_word;

    assign cmd        = s_tdata[1:0];
    assign push_value = s_tdata[33:2];
    assign push_wide  = 64'($signed(push_value));
    assign push_word  = push_wide[DATA_WIDTH-1:0];

    // control state
    logic              state_reg, state_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       popped_reg, popped_next;
    logic [1:0]        status_reg, status_next;
    logic [CNT_W-1:0]  ocount_reg, ocount_next;

    cell_ctrl_t ctrl;

    // cell chain taps
    logic [DEPTH-1:0]      cell_valid;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_tail [DEPTH];

    logic        in_xfer, out_free, is_full, is_zero, load_out;
    logic [63:0] front_wide, back_wide;

    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign in_xfer    = s_tvalid && s_tready;
    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign is_zero    = (count_reg == '0);
    assign front_wide = 64'($signed(cell_data[0]));
    assign back_wide  = 64'($signed(cell_tail[0]));

    always_comb begin
        state_next  = state_reg;
        wait_next   = wait_reg;
        count_next  = count_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        ocount_next = ocount_reg;
        load_out    = 1'b0;
        ctrl.op     = OP_HOLD;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    popped_next = '0;
                    status_next = ST_DONE;
                    unique case (cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            load_out = 1'b1;
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                ctrl.op    = (cmd == CMD_PUSH_FRONT) ? OP_PUSH_FRONT
                                                                     : OP_PUSH_BACK;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            load_out = 1'b1;
                            if (is_zero) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ctrl.op     = OP_POP_FRONT;
                                popped_next = front_wide[31:0];
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        default: begin
                            // pop back: empty completes now, otherwise let the
                            // tail word travel down the chain
                            if (is_zero) begin
                                load_out    = 1'b1;
                                status_next = ST_EMPTY;
                            end else begin
                                state_next = ST_WAIT;
                                wait_next  = '0;
                            end
                        end
                    endcase
                    ocount_next = count_next;
                end
            end
            default: begin
                // cell valid and data hold here while the tail word settles into cell_tail[0]
                if (wait_reg != WAIT_W'(DEPTH - 1)) begin
                    wait_next = wait_reg + 1'b1;
                end else if (out_free) begin
                    load_out    = 1'b1;
                    ctrl.op     = OP_POP_BACK;
                    popped_next = back_wide[31:0];
                    status_next = ST_DONE;
                    count_next  = count_reg - 1'b1;
                    ocount_next = count_next;
                    state_next  = ST_IDLE;
                end
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wait_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            popped_reg <= popped_next;
            status_reg <= status_next;
            ocount_reg <= ocount_next;
        end
    end

    // cell chain: cell 0 is the front; its left neighbor is the incoming word
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  lv, rv;
        logic [DATA_WIDTH-1:0] ld, rd, rt;

        if (i == 0) begin : g_first
            assign lv = 1'b1;
            assign ld = push_word;
        end else begin : g_mid_l
            assign lv = cell_valid[i-1];
            assign ld = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign rv = 1'b0;
            assign rd = '0;
            assign rt = '0;
        end else begin : g_mid_r
            assign rv = cell_valid[i+1];
            assign rd = cell_data[i+1];
            assign rt = cell_tail[i+1];
        end

        dq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .left_valid (lv),
            .left_data  (ld),
            .right_valid(rv),
            .right_data (rd),
            .right_tail (rt),
            .push_word  (push_word),
            .valid      (cell_valid[i]),
            .data       (cell_data[i]),
            .tail       (cell_tail[i])
        );
    end

    assign m_tvalid = m_valid_reg;

    // fields from bit 0 up, padding bits stay zero
    always_comb begin
        m_tdata = '0;
        m_tdata[34+CNT_W:0] = {(ocount_reg == '0), ocount_reg, status_reg, popped_reg};
    end

    // checks
    `DQ_ASSERT(a_count_range, count_reg <= CNT_W'(DEPTH), "count exceeds depth")
    `DQ_ASSERT(a_front_valid, (count_reg == '0) == !cell_valid[0], "front cell disagrees with count")
    `DQ_ASSERT(a_wait_blocks, (state_reg == ST_WAIT) |-> !s_tready, "input taken during pop-back wait")
    `DQ_ASSERT(a_pop_front_dec, (in_xfer && cmd == CMD_POP_FRONT && !is_zero) |=> (count_reg == $past(count_reg) - 1'b1), "pop front did not decrement count")
    `DQ_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> (count_reg == '0 && !m_valid_reg), "reset did not clear state")

endmodule

`default_nettype wire
